// ----- rtl/sirf_pkg.sv -----
// Package for the sparse internal register file: transfer payload types,
// operation and status codes, and the fixed addresses of the named registers.
// Used by sirf_regs and sparse_internal_register_file; depends on nothing.
`timescale 1ns / 1ps

package sirf_pkg;

  // Operation codes carried in the operation field.
  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_READ      = 2'd1;
  localparam logic [1:0] OP_PTR_RESET = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_ALLOC = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // Named registers: buffer-zero base, buffer-one base, buffer-zero pointer,
  // buffer-one pointer, PM base and PM mask, in that order.
  localparam int unsigned NAMED_COUNT = 6;
  localparam int unsigned NAMED_IDX_W = 3;
  localparam logic [NAMED_IDX_W-1:0] BB1_BASE_IDX = 3'd1;
  localparam logic [NAMED_IDX_W-1:0] BB1_PTR_IDX  = 3'd3;

  localparam logic [31:0] NAMED_ADDR [NAMED_COUNT] = '{
    32'hFFFF_FF0C, 32'hFFFF_FF1C, 32'hFFFF_FF2C,
    32'hFFFF_FF3C, 32'hFFFF_FF6C, 32'hFFFF_FF7C
  };

  // Request payload.
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] reg_address;
    logic [31:0] write_data;
  } in_item_t;

  // Response payload.
  typedef struct packed {
    logic [31:0] read_data;
    status_t     status;
  } out_item_t;

endpackage

// ----- rtl/sirf_regs.sv -----
// Register storage of the sparse internal register file: six named registers,
// the learned overflow table with its fill count, the parallel address match
// and the state update. Depends on sirf_pkg.
`timescale 1ns / 1ps

module sirf_regs #(
  parameter int unsigned OVERFLOW_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  sirf_pkg::in_item_t item,
  output sirf_pkg::out_item_t result
);

  localparam int unsigned COUNT_W = $clog2(OVERFLOW_DEPTH + 1);
  localparam int unsigned IDX_W   = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;

  logic [31:0] named_values [sirf_pkg::NAMED_COUNT];
  logic [31:0] learned_addresses [OVERFLOW_DEPTH];
  logic [31:0] learned_values [OVERFLOW_DEPTH];
  logic [COUNT_W-1:0] learned_count;

  logic [sirf_pkg::NAMED_COUNT-1:0] named_hit;
  logic [OVERFLOW_DEPTH-1:0]        learned_hit;
  logic [31:0] hit_value;
  logic        hit;
  logic        full;
  logic        do_alloc;
  logic [IDX_W-1:0] alloc_idx;

  // Parallel compare against every named address and every filled slot.
  // Matches are exclusive, so the hit value is an OR of the masked entries.
  always_comb begin
    hit_value = '0;
    for (int k = 0; k < sirf_pkg::NAMED_COUNT; k++) begin
      named_hit[k] = (item.reg_address == sirf_pkg::NAMED_ADDR[k]);
      hit_value    = hit_value | (named_values[k] & {32{named_hit[k]}});
    end
    for (int i = 0; i < OVERFLOW_DEPTH; i++) begin
      learned_hit[i] = (COUNT_W'(i) < learned_count) &&
                       (learned_addresses[i] == item.reg_address);
      hit_value      = hit_value | (learned_values[i] & {32{learned_hit[i]}});
    end
  end

  assign hit       = (|named_hit) || (|learned_hit);
  assign full      = (learned_count == COUNT_W'(OVERFLOW_DEPTH));
  assign alloc_idx = learned_count[IDX_W-1:0];
  assign do_alloc  = fire && (item.operation == sirf_pkg::OP_WRITE) && !hit && !full;

  // Result of the operation, taken from the state before the update.
  always_comb begin
    result.read_data = '0;
    result.status    = sirf_pkg::ST_HIT;
    case (item.operation)
      sirf_pkg::OP_WRITE: begin
        if (hit) begin
          result.status = sirf_pkg::ST_HIT;
        end else if (full) begin
          result.status = sirf_pkg::ST_FULL;
        end else begin
          result.status = sirf_pkg::ST_ALLOC;
        end
      end
      sirf_pkg::OP_READ: begin
        if (hit) begin
          result.read_data = hit_value;
        end else begin
          result.status = sirf_pkg::ST_MISS;
        end
      end
      sirf_pkg::OP_PTR_RESET: begin
        result.read_data = named_values[sirf_pkg::BB1_BASE_IDX];
      end
      default: begin
        result.read_data = '0;
        result.status    = sirf_pkg::ST_HIT;
      end
    endcase
  end

  // Named registers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < sirf_pkg::NAMED_COUNT; k++) begin
        named_values[k] <= '0;
      end
      learned_count <= '0;
    end else if (fire) begin
      if (item.operation == sirf_pkg::OP_WRITE) begin
        for (int k = 0; k < sirf_pkg::NAMED_COUNT; k++) begin
          if (named_hit[k]) begin
            named_values[k] <= item.write_data;
          end
        end
      end else if (item.operation == sirf_pkg::OP_PTR_RESET) begin
        named_values[sirf_pkg::BB1_PTR_IDX] <= named_values[sirf_pkg::BB1_BASE_IDX];
      end
      if (do_alloc) begin
        learned_count <= learned_count + COUNT_W'(1);
      end
    end
  end

  // Learned table: write hits update in place, a write miss fills the next slot unless the table is full.
  always_ff @(posedge clk) begin
    if (fire && (item.operation == sirf_pkg::OP_WRITE)) begin
      for (int i = 0; i < OVERFLOW_DEPTH; i++) begin
        if (learned_hit[i]) begin
          learned_values[i] <= item.write_data;
        end
      end
    end
    if (do_alloc) begin
      learned_addresses[alloc_idx] <= item.reg_address;
      learned_values[alloc_idx]    <= item.write_data;
    end
  end

endmodule

// ----- rtl/sparse_internal_register_file.sv -----
// Top level of the sparse internal register file: input register, result
// register and the valid/ready control around them. Depends on sirf_pkg
// and sirf_regs.
`timescale 1ns / 1ps

// A sparse 32-bit register space with six named registers at fixed addresses
// and an overflow table of OVERFLOW_DEPTH slots that learns new addresses in
// order of first write. Every request gives exactly one response. A request
// is held in an input register and resolved from there into the result
// register, so the block takes one request per cycle while the output side
// is not stalled. Between the two registers lie the parallel compare of the
// address against the six named addresses and every filled slot and the
// value select. No clearing pass is needed after reset: a slot counts only
// once it is filled. A write that misses with the table full changes nothing
// and reports it.

module sparse_internal_register_file #(
  parameter int unsigned OVERFLOW_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sirf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sirf_pkg::out_item_t out_item
);

  sirf_pkg::in_item_t  req;
  logic                req_valid;
  sirf_pkg::out_item_t result;
  logic                fire;

  // A held request is resolved when the result register is free or draining.
  assign fire     = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req <= in_item;
    end
  end

  sirf_regs #(
    .OVERFLOW_DEPTH(OVERFLOW_DEPTH)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (req),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

endmodule
